/* hdl/itc_pkg.sv */
// ----------------------------------------------------------------------------
// itc_pkg
// types, constants and helpers shared by the interval traffic counters
// ----------------------------------------------------------------------------
package itc_pkg;

    localparam int TIME_BITS   = 48;
    localparam int COUNT_BITS  = 32;
    localparam int BYTE_BITS   = 48;
    localparam int WIN_BITS    = 32;
    localparam int LEN_BITS    = 16;
    localparam int DIV_STEPS   = TIME_BITS;
    localparam int STEP_BITS   = $clog2(DIV_STEPS);

    localparam logic [WIN_BITS-1:0] WINDOW_RESET   = 32'd1000000;
    localparam logic [LEN_BITS-1:0] MIN_IP_FRAME   = 16'd34;
    localparam logic [15:0]         ETH_IPV4       = 16'h0800;
    localparam logic [7:0]          PROTO_TCP      = 8'd6;
    localparam logic [7:0]          PROTO_UDP      = 8'd17;
    localparam logic [7:0]          PROTO_ICMP     = 8'd1;
    localparam logic                KIND_PACKET    = 1'b0;
    localparam logic                KIND_FLUSH     = 1'b1;

    typedef struct packed {
        logic                  kind;
        logic [TIME_BITS-1:0]  timestamp_us;
        logic [LEN_BITS-1:0]   frame_length;
        logic [15:0]           ether_type;
        logic [7:0]            ip_protocol;
    } in_item_t;

    typedef struct packed {
        logic [TIME_BITS-1:0]  window_start_us;
        logic [COUNT_BITS-1:0] packets;
        logic [BYTE_BITS-1:0]  bytes;
        logic [COUNT_BITS-1:0] tcp_packets;
        logic [COUNT_BITS-1:0] udp_packets;
        logic [COUNT_BITS-1:0] icmp_packets;
        logic [COUNT_BITS-1:0] other_packets;
        logic [COUNT_BITS-1:0] empty_windows_after;
    } out_item_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] packets;
        logic [BYTE_BITS-1:0]  bytes;
        logic [COUNT_BITS-1:0] tcp;
        logic [COUNT_BITS-1:0] udp;
        logic [COUNT_BITS-1:0] icmp;
        logic [COUNT_BITS-1:0] other;
    } counts_t;

    typedef struct packed {
        logic                  start;
        logic [TIME_BITS-1:0]  dividend;
        logic [WIN_BITS-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [TIME_BITS-1:0]  quotient;
        logic [WIN_BITS-1:0]   remainder;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIV,
        ST_EMIT
    } state_t;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS-1:0] r;
        r = (&v) ? v : v + COUNT_BITS'(1);
        return r;
    endfunction

    function automatic counts_t count_packet(input counts_t c, input in_item_t it);
        counts_t            r;
        logic [BYTE_BITS:0] sum;
        r = c;
        r.packets = sat_inc(c.packets);
        sum = {1'b0, c.bytes} + (BYTE_BITS+1)'(it.frame_length);
        r.bytes = sum[BYTE_BITS] ? {BYTE_BITS{1'b1}} : sum[BYTE_BITS-1:0];
        if (it.frame_length < MIN_IP_FRAME || it.ether_type != ETH_IPV4)
        begin
            r.other = sat_inc(c.other);
        end
        else if (it.ip_protocol == PROTO_TCP)
        begin
            r.tcp = sat_inc(c.tcp);
        end
        else if (it.ip_protocol == PROTO_UDP)
        begin
            r.udp = sat_inc(c.udp);
        end
        else if (it.ip_protocol == PROTO_ICMP)
        begin
            r.icmp = sat_inc(c.icmp);
        end
        else
        begin
            r.other = sat_inc(c.other);
        end
        return r;
    endfunction

endpackage

/* hdl/itc_div.sv */
// ----------------------------------------------------------------------------
// itc_div
// restoring divider, one quotient bit per cycle, for window alignment
// ----------------------------------------------------------------------------
module itc_div (
    input  logic             clk,
    input  logic             rst_n,
    input  itc_pkg::div_req_t req,
    output itc_pkg::div_rsp_t rsp
);
    import itc_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic [TIME_BITS-1:0] quo_reg, quo_next;
    logic [WIN_BITS-1:0]  rem_reg, rem_next;
    logic [WIN_BITS-1:0]  div_reg, div_next;

    logic [WIN_BITS:0]    rem_shift;
    logic                 ge;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[TIME_BITS-1]};
        ge        = rem_shift >= {1'b0, div_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[TIME_BITS-2:0], ge};
            rem_next = ge ? WIN_BITS'(rem_shift - {1'b0, div_reg}) : rem_shift[WIN_BITS-1:0];
            if (step_reg == STEP_BITS'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                step_next = step_reg + STEP_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !req.start)
        else $error("divider restarted while busy");

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a finished run");

    a_zero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> req.divisor != '0)
        else $error("divider started with zero divisor");

endmodule

/* hdl/interval_traffic_counters.sv */
// ----------------------------------------------------------------------------
// interval_traffic_counters
// per-window packet, byte and protocol counts from timestamped packet events
// ----------------------------------------------------------------------------
// in channel: one transaction per packet event or flush (kind = 1)
// out channel: one transaction per closed window, carrying its counts and the
//   number of empty windows skipped before the new packet's window
// cfg channel: window length in microseconds, always ready, write when idle
// a packet inside the open window is accepted, then classified and counted
// the first packet after reset or flush, and a packet past the open window,
//   run the shared restoring divider, one quotient bit per cycle; a packet
//   past the window may then wait in the emit state for the out register
// a flush of an open window passes through the decide and emit states
// the result sits in an output register; new items are accepted while it
//   waits, and the block only stalls on the output when a second result is
//   ready before the first was taken
// reset: no window open, all counts zero, window length 1000000
// ----------------------------------------------------------------------------
module interval_traffic_counters (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  itc_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output itc_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data
);
    import itc_pkg::*;

    state_t               state_reg, state_next;
    in_item_t             item_reg;
    logic [WIN_BITS-1:0]  window_reg, window_next;
    logic                 open_reg, open_next;
    logic [TIME_BITS-1:0] start_reg, start_next;
    counts_t              counts_reg, counts_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_data_reg, out_data_next;

    div_req_t             div_req;
    div_rsp_t             div_rsp;

    logic [WIN_BITS-1:0]  w_eff;
    logic [TIME_BITS-1:0] delta;
    logic                 rollover;
    logic [TIME_BITS-1:0] new_start;
    logic [TIME_BITS-1:0] k_minus1;
    logic                 out_free;
    counts_t              fresh;

    itc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        w_eff     = (window_reg == '0) ? WIN_BITS'(1) : window_reg;
        delta     = item_reg.timestamp_us - start_reg;
        rollover  = (item_reg.timestamp_us >= start_reg)
                    && (delta >= TIME_BITS'(w_eff));
        new_start = item_reg.timestamp_us - TIME_BITS'(div_rsp.remainder);
        k_minus1  = div_rsp.quotient - TIME_BITS'(1);
        out_free  = !out_valid_reg || out_ready;
        fresh     = count_packet('0, item_reg);

        state_next     = state_reg;
        window_next    = window_reg;
        open_next      = open_reg;
        start_next     = start_reg;
        counts_next    = counts_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        div_req.start    = 1'b0;
        div_req.dividend = open_reg ? delta : item_reg.timestamp_us;
        div_req.divisor  = w_eff;

        if (cfg_valid)
        begin
            window_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (item_reg.kind == KIND_FLUSH)
                begin
                    state_next = open_reg ? ST_EMIT : ST_IDLE;
                end
                else if (!open_reg || rollover)
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    counts_next = count_packet(counts_reg, item_reg);
                    state_next  = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (open_reg)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        open_next   = 1'b1;
                        start_next  = new_start;
                        counts_next = fresh;
                        state_next  = ST_IDLE;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next                    = 1'b1;
                    out_data_next.window_start_us     = start_reg;
                    out_data_next.packets             = counts_reg.packets;
                    out_data_next.bytes               = counts_reg.bytes;
                    out_data_next.tcp_packets         = counts_reg.tcp;
                    out_data_next.udp_packets         = counts_reg.udp;
                    out_data_next.icmp_packets        = counts_reg.icmp;
                    out_data_next.other_packets       = counts_reg.other;
                    if (item_reg.kind == KIND_FLUSH)
                    begin
                        out_data_next.empty_windows_after = '0;
                        open_next   = 1'b0;
                        start_next  = '0;
                        counts_next = '0;
                    end
                    else
                    begin
                        out_data_next.empty_windows_after =
                            (|k_minus1[TIME_BITS-1:COUNT_BITS]) ? {COUNT_BITS{1'b1}}
                                                                : k_minus1[COUNT_BITS-1:0];
                        start_next  = new_start;
                        counts_next = fresh;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            window_reg    <= WINDOW_RESET;
            open_reg      <= 1'b0;
            start_reg     <= '0;
            counts_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            open_reg      <= open_next;
            start_reg     <= start_next;
            counts_reg    <= counts_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_closed_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !open_reg |-> counts_reg == '0 && start_reg == '0)
        else $error("counts present with no open window");

    a_open_has_packet: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> counts_reg.packets != '0)
        else $error("open window without a counted packet");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_data_reg))
        else $error("pending result overwritten");

endmodule

/* tb/sv/tb_interval_traffic_counters.sv */
// ----------------------------------------------------------------------------
// tb_interval_traffic_counters
// self-checking bench for the per-window packet, byte and protocol counters:
// a directed pass over field extremes, packet classes, early packets, flushes,
// skipped windows and zero, minimum and maximum window lengths, then random
// traffic under three window lengths with varied idling on both channels;
// every window the block emits is checked against an in-bench predictor
// ----------------------------------------------------------------------------
module tb_interval_traffic_counters;

    timeunit 1ns;
    timeprecision 1ps;

    import itc_pkg::*;

    localparam int        LIMIT  = 1000000;
    localparam int        QUIET  = 150;
    localparam bit [47:0] TS_MAX = 48'hFFFF_FFFF_FFFF;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    in_item_t    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data  = '0;

    in_item_t    pending_events[$];
    out_item_t   expected_windows[$];

    int          send_idle     = 6;
    int          recv_idle     = 69;
    int          events_taken  = 0;
    int          windows_seen  = 0;
    int          mismatches    = 0;
    int          cycle_count   = 0;
    int          directed_cnt  = 0;
    bit [47:0]   ts_cursor;

    // predictor state
    bit [31:0]   win_len   = WINDOW_RESET;
    bit          win_open  = 1'b0;
    bit [47:0]   win_start = '0;
    bit [31:0]   n_pkt, n_tcp, n_udp, n_icmp, n_other;
    bit [47:0]   n_bytes;

    interval_traffic_counters u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic bit [31:0] bump(input bit [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic void clear_tally();
        n_pkt   = '0;
        n_bytes = '0;
        n_tcp   = '0;
        n_udp   = '0;
        n_icmp  = '0;
        n_other = '0;
    endfunction

    function automatic out_item_t closed_window(input bit [63:0] empties);
        out_item_t r;
        r.window_start_us     = win_start;
        r.packets             = n_pkt;
        r.bytes               = n_bytes;
        r.tcp_packets         = n_tcp;
        r.udp_packets         = n_udp;
        r.icmp_packets        = n_icmp;
        r.other_packets       = n_other;
        r.empty_windows_after = (empties > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : empties[31:0];
        return r;
    endfunction

    task automatic account_event(input in_item_t it);
        bit [63:0] w;
        bit [63:0] t;
        bit [63:0] k;
        bit [48:0] sum;
        w = (win_len == 0) ? 64'd1 : {32'd0, win_len};
        t = {16'd0, it.timestamp_us};
        if (it.kind == KIND_FLUSH)
        begin
            if (win_open)
            begin
                expected_windows.push_back(closed_window(64'd0));
                win_open  = 1'b0;
                win_start = '0;
                clear_tally();
            end
        end
        else
        begin
            if (!win_open)
            begin
                win_start = 48'((t / w) * w);
                win_open  = 1'b1;
                clear_tally();
            end
            else if (t >= win_start && t - win_start >= w)
            begin
                k = (t - win_start) / w;
                expected_windows.push_back(closed_window(k - 64'd1));
                win_start = 48'(win_start + k * w);
                clear_tally();
            end
            n_pkt   = bump(n_pkt);
            sum     = {1'b0, n_bytes} + 49'(it.frame_length);
            n_bytes = sum[48] ? '1 : sum[47:0];
            if (it.frame_length < MIN_IP_FRAME || it.ether_type != ETH_IPV4)
                n_other = bump(n_other);
            else if (it.ip_protocol == PROTO_TCP)
                n_tcp = bump(n_tcp);
            else if (it.ip_protocol == PROTO_UDP)
                n_udp = bump(n_udp);
            else if (it.ip_protocol == PROTO_ICMP)
                n_icmp = bump(n_icmp);
            else
                n_other = bump(n_other);
        end
    endtask

    function automatic bit count_mismatch();
        mismatches++;
        return mismatches <= 10;
    endfunction

    task automatic compare_field(input string name, input bit [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            if (count_mismatch())
                $display("window %0d: %s expected %0d got %0d", windows_seen, name, want, got);
        end
    endtask

    task automatic check_window(input out_item_t got);
        out_item_t want;
        windows_seen++;
        if (expected_windows.size() == 0)
        begin
            if (count_mismatch())
                $display("window %0d: unexpected transaction, start %0d", windows_seen,
                         got.window_start_us);
        end
        else
        begin
            want = expected_windows.pop_front();
            compare_field("window_start_us", want.window_start_us, got.window_start_us);
            compare_field("packets", want.packets, got.packets);
            compare_field("bytes", want.bytes, got.bytes);
            compare_field("tcp_packets", want.tcp_packets, got.tcp_packets);
            compare_field("udp_packets", want.udp_packets, got.udp_packets);
            compare_field("icmp_packets", want.icmp_packets, got.icmp_packets);
            compare_field("other_packets", want.other_packets, got.other_packets);
            compare_field("empty_windows_after", want.empty_windows_after,
                          got.empty_windows_after);
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                account_event(in_data);
                events_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    in_data  <= pending_events.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_window(out_data);
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("timeout after %0d cycles, %0d windows outstanding", LIMIT,
                     expected_windows.size());
            $display("tb_interval_traffic_counters NOT OK");
            $finish;
        end
    end

    function automatic bit [47:0] rand48();
        return {16'($urandom()), 32'($urandom())};
    endfunction

    function automatic in_item_t make_item(input logic kind, input bit [47:0] ts,
                                           input bit [15:0] len, input bit [15:0] et,
                                           input bit [7:0] pr);
        in_item_t r;
        r.kind         = kind;
        r.timestamp_us = ts;
        r.frame_length = len;
        r.ether_type   = et;
        r.ip_protocol  = pr;
        return r;
    endfunction

    task automatic add_packet(input bit [47:0] ts, input bit [15:0] len,
                              input bit [15:0] et, input bit [7:0] pr);
        pending_events.push_back(make_item(KIND_PACKET, ts, len, et, pr));
        directed_cnt++;
    endtask

    task automatic add_flush();
        pending_events.push_back(make_item(KIND_FLUSH, rand48(), 16'($urandom()),
                                           16'($urandom()), 8'($urandom())));
        directed_cnt++;
    endtask

    task automatic settle();
        while (!(pending_events.size() == 0 && !in_valid && expected_windows.size() == 0))
            @(posedge clk);
        repeat (QUIET) @(posedge clk);
    endtask

    task automatic write_window(input bit [31:0] v);
        settle();
        @(posedge clk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        win_len = v;
    endtask

    // mostly ordered traffic with random content, plus early, noisy and flush events
    task automatic queue_traffic(input int n, input bit [31:0] wl);
        bit [63:0]  w;
        bit [63:0]  step;
        bit [47:0]  ts;
        bit [15:0]  len;
        bit [15:0]  et;
        bit [7:0]   pr;
        int         pick;
        int         r;
        w = (wl == 0) ? 64'd1 : {32'd0, wl};
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
            begin
                pending_events.push_back(make_item(KIND_FLUSH, rand48(), 16'($urandom()),
                                                   16'($urandom()), 8'($urandom())));
                continue;
            end
            if (pick < 6)
            begin
                ts_cursor = rand48();
                ts        = ts_cursor;
            end
            else if (pick < 10)
            begin
                step = {32'd0, $urandom()} % (2 * w + 1);
                ts   = (ts_cursor > step) ? ts_cursor - 48'(step) : 48'd0;
            end
            else
            begin
                if (pick < 25)
                    step = w * $urandom_range(1, 2) + {32'd0, $urandom()} % w;
                else if (pick < 30)
                    step = w * $urandom_range(3, 2000);
                else
                    step = {32'd0, $urandom()} % (w / 4 + 1);
                ts_cursor = ts_cursor + 48'(step);
                ts        = ts_cursor;
            end
            r = $urandom_range(0, 9);
            if (r < 1)
                len = 16'($urandom_range(0, 33));
            else if (r < 2)
                len = 16'($urandom());
            else
                len = 16'($urandom_range(34, 1518));
            et = ($urandom_range(0, 9) < 8) ? ETH_IPV4 : 16'($urandom());
            r  = $urandom_range(0, 9);
            if (r < 3)
                pr = PROTO_TCP;
            else if (r < 6)
                pr = PROTO_UDP;
            else if (r < 7)
                pr = PROTO_ICMP;
            else
                pr = 8'($urandom());
            pending_events.push_back(make_item(KIND_PACKET, ts, len, et, pr));
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset window length: classes, early packet, rollover, skips, flushes
        add_flush();
        add_packet(48'd2500123, 16'd0, ETH_IPV4, PROTO_TCP);
        add_packet(48'd2000000, 16'd34, ETH_IPV4, PROTO_TCP);
        add_packet(48'd2999999, 16'hFFFF, ETH_IPV4, PROTO_UDP);
        add_packet(48'd1000, 16'd100, ETH_IPV4, PROTO_ICMP);
        add_packet(48'd2100000, 16'd33, ETH_IPV4, PROTO_UDP);
        add_packet(48'd2200000, 16'd60, 16'h86DD, PROTO_TCP);
        add_packet(48'd2300000, 16'd60, ETH_IPV4, 8'hFF);
        add_packet(48'd3000000, 16'd60, ETH_IPV4, 8'h00);
        add_packet(48'd7500000, 16'd1500, ETH_IPV4, PROTO_TCP);
        add_flush();
        add_flush();

        // shortest window: skip count saturates
        write_window(32'd1);
        add_packet(48'd0, 16'd64, ETH_IPV4, PROTO_TCP);
        add_packet(TS_MAX, 16'hFFFF, 16'hFFFF, 8'hFF);
        add_packet(TS_MAX, 16'd40, ETH_IPV4, PROTO_UDP);
        add_flush();

        // zero length acts as one
        write_window(32'd0);
        add_packet(48'd5, 16'd64, ETH_IPV4, PROTO_ICMP);
        add_packet(48'd5, 16'd64, ETH_IPV4, PROTO_UDP);
        add_packet(48'd6, 16'd64, ETH_IPV4, PROTO_TCP);
        add_packet(48'd9, 16'd64, 16'h0000, PROTO_TCP);
        add_flush();

        // longest window
        write_window(32'hFFFF_FFFF);
        add_packet(48'd4294967294, 16'd200, ETH_IPV4, PROTO_TCP);
        add_packet(48'd4294967295, 16'd200, ETH_IPV4, PROTO_UDP);
        add_packet(48'd0, 16'd200, ETH_IPV4, PROTO_ICMP);
        add_packet(TS_MAX, 16'd200, ETH_IPV4, PROTO_TCP);
        add_flush();

        write_window(32'd1000);
        ts_cursor = 48'($urandom_range(0, 1000000));
        queue_traffic(250, 32'd1000);
        settle();
        queue_traffic(250, 32'd1000);

        write_window(32'd7);
        send_idle = 69;
        recv_idle = 6;
        queue_traffic(500, 32'd7);

        write_window(32'd250000);
        send_idle = 0;
        recv_idle = 0;
        queue_traffic(500, 32'd250000);

        settle();
        $display("%0d events sent (%0d directed), %0d windows checked", events_taken,
                 directed_cnt, windows_seen);
        $display("window lengths 1000000, 1, 0, max, 1000, 7 and 250000; %0d mismatches",
                 mismatches + expected_windows.size());
        if (mismatches == 0 && expected_windows.size() == 0)
            $display("tb_interval_traffic_counters OK");
        else
            $display("tb_interval_traffic_counters NOT OK");
        $finish;
    end

endmodule
